[hw/rtl/pbb_pkg.sv]
`default_nettype none
package pbb_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int SCREEN_BITS = 13;
  localparam int SCALE_BITS  = 16;
  localparam int PROD_BITS   = COORD_WIDTH + SCALE_BITS;
  localparam int ITER_BITS   = $clog2(SCREEN_BITS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  localparam logic [1:0] REG_SCREEN_W = 2'd0;
  localparam logic [1:0] REG_SCREEN_H = 2'd1;
  localparam logic [1:0] REG_FOCAL    = 2'd2;

  localparam logic [SCREEN_BITS-1:0] SCREEN_W_RESET = SCREEN_BITS'(640);
  localparam logic [SCREEN_BITS-1:0] SCREEN_H_RESET = SCREEN_BITS'(480);
  localparam logic [SCALE_BITS-1:0]  FOCAL_RESET    = SCALE_BITS'(256);

  typedef struct packed {
    logic [SCREEN_BITS-1:0] screen_w;
    logic [SCREEN_BITS-1:0] screen_h;
    logic [SCALE_BITS-1:0]  focal;
  } cfg_t;

  // One classified vertex as it waits between the front and the back end.
  typedef struct packed {
    logic [COORD_WIDTH-1:0] x_mag;
    logic                   x_neg;
    logic [COORD_WIDTH-1:0] y_mag;
    logic                   y_neg;
    logic [COORD_WIDTH-2:0] z_mag;
    logic                   behind;
    logic                   last;
  } vert_entry_t;

  typedef struct packed {
    logic                   start;
    logic [COORD_WIDTH-1:0] mag;
    logic [COORD_WIDTH-2:0] den;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [SCREEN_BITS-1:0] quo;
  } div_rsp_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_CHECK,
    DV_ITER
  } div_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV_X,
    BK_DIV_Y,
    BK_FINISH
  } back_state_e;

endpackage
`default_nettype wire

[hw/rtl/pbb_if.sv]
`default_nettype none
interface pbb_vert_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pbb_pkg::COORD_WIDTH-1:0] vert_x;
  logic signed [pbb_pkg::COORD_WIDTH-1:0] vert_y;
  logic signed [pbb_pkg::COORD_WIDTH-1:0] vert_z;
  logic                                   last_vertex;

  modport source (output valid, output vert_x, output vert_y, output vert_z,
                  output last_vertex, input ready);
  modport sink   (input valid, input vert_x, input vert_y, input vert_z,
                  input last_vertex, output ready);
endinterface

interface pbb_box_if;
  logic                            valid;
  logic                            ready;
  logic [pbb_pkg::SCREEN_BITS-1:0] box_x;
  logic [pbb_pkg::SCREEN_BITS-1:0] box_y;
  logic [pbb_pkg::SCREEN_BITS-1:0] box_w;
  logic [pbb_pkg::SCREEN_BITS-1:0] box_h;
  logic                            behind_camera;

  modport source (output valid, output box_x, output box_y, output box_w,
                  output box_h, output behind_camera, input ready);
  modport sink   (input valid, input box_x, input box_y, input box_w,
                  input box_h, input behind_camera, output ready);
endinterface
`default_nettype wire

[hw/rtl/perspective_bounding_box.sv]
// Screen bounding box of one projected object.
// Vertices arrive on vert_i (valid/ready) as signed Q16.16 x, y, z with a
// last-vertex mark; one box per object leaves on box_o when the last vertex
// has been processed. An item is transferred when valid and ready are high.
// Each vertex with z > 0 is projected as x*focal/z and y*focal/z by one shared
// multiply-and-divide unit: a multiply step, a range check and 13 restoring
// steps per axis. A vertex with z <= 0 forces an all-zero box with
// behind_camera set.
// A two-entry queue sits between the input side and the divider. The vertex
// being divided keeps its entry, so one more vertex is taken meanwhile.
// The box sits in an output register; while box_o is stalled the block keeps
// working on the next object and blocks only when a second box is ready.
// Reset empties the queue, drops any pending box, restores the screen size
// (640 x 480) and focal scale (256) and arms the block for a new object.
// Registers are written over APB at byte addresses 0, 4 and 8.
`default_nettype none
module perspective_bounding_box (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  pbb_vert_if.sink                             vert_i,
  pbb_box_if.source                            box_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pbb_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [pbb_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [pbb_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);
  import pbb_pkg::*;

  cfg_t        cfg_q;
  logic        cfg_wr;
  logic [1:0]  reg_idx;
  logic        push;
  logic        full;
  vert_entry_t push_entry;
  logic        q_valid;
  logic        q_pop;
  vert_entry_t q_entry;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_w <= SCREEN_W_RESET;
      cfg_q.screen_h <= SCREEN_H_RESET;
      cfg_q.focal    <= FOCAL_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SCREEN_W: cfg_q.screen_w <= pwdata[SCREEN_BITS-1:0];
        REG_SCREEN_H: cfg_q.screen_h <= pwdata[SCREEN_BITS-1:0];
        REG_FOCAL:    cfg_q.focal    <= pwdata[SCALE_BITS-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCREEN_W: prdata = APB_DATA_BITS'(cfg_q.screen_w);
      REG_SCREEN_H: prdata = APB_DATA_BITS'(cfg_q.screen_h);
      REG_FOCAL:    prdata = APB_DATA_BITS'(cfg_q.focal);
      default:      prdata = '0;
    endcase
  end

  pbb_front u_front (
    .vert_i  (vert_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  pbb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  pbb_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .focal_i (cfg_q.focal),
    .req_i   (div_req),
    .rsp_o   (div_rsp)
  );

  pbb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .box_o     (box_o)
  );
endmodule
`default_nettype wire

[hw/rtl/pbb_front.sv]
`default_nettype none
module pbb_front (
  pbb_vert_if.sink              vert_i,
  input  logic                  full_i,
  output logic                  push_o,
  output pbb_pkg::vert_entry_t  entry_o
);
  import pbb_pkg::*;

  logic [COORD_WIDTH-1:0] x_raw;
  logic [COORD_WIDTH-1:0] y_raw;
  logic [COORD_WIDTH-1:0] z_raw;

  assign x_raw = vert_i.vert_x;
  assign y_raw = vert_i.vert_y;
  assign z_raw = vert_i.vert_z;

  assign vert_i.ready = !full_i;
  assign push_o       = vert_i.valid && !full_i;

  // Split x and y into sign and magnitude; the most negative value keeps its
  // full magnitude in the unsigned field.
  always_comb begin
    entry_o.x_neg  = x_raw[COORD_WIDTH-1];
    entry_o.x_mag  = x_raw[COORD_WIDTH-1] ? (~x_raw + COORD_WIDTH'(1)) : x_raw;
    entry_o.y_neg  = y_raw[COORD_WIDTH-1];
    entry_o.y_mag  = y_raw[COORD_WIDTH-1] ? (~y_raw + COORD_WIDTH'(1)) : y_raw;
    entry_o.z_mag  = z_raw[COORD_WIDTH-2:0];
    entry_o.behind = z_raw[COORD_WIDTH-1] || (z_raw == '0);
    entry_o.last   = vert_i.last_vertex;
  end
endmodule
`default_nettype wire

[hw/rtl/pbb_queue.sv]
`default_nettype none
module pbb_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pbb_pkg::vert_entry_t entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output pbb_pkg::vert_entry_t entry_o
);
  import pbb_pkg::*;

  vert_entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0]   count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  assign full_o  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/pbb_divider.sv]
`default_nettype none
module pbb_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [pbb_pkg::SCALE_BITS-1:0]    focal_i,
  input  pbb_pkg::div_req_t                 req_i,
  output pbb_pkg::div_rsp_t                 rsp_o
);
  import pbb_pkg::*;

  div_state_e             state_q, state_d;
  logic [COORD_WIDTH-1:0] mag_q, mag_d;
  logic [COORD_WIDTH-2:0] den_q, den_d;
  logic [PROD_BITS-1:0]   rem_q, rem_d;
  logic [PROD_BITS-1:0]   dsh_q, dsh_d;
  logic [SCREEN_BITS-1:0] quo_q, quo_d;
  logic [ITER_BITS-1:0]   cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [PROD_BITS-1:0]   prod;
  logic                   ge;

  assign prod = mag_q * focal_i;
  assign ge   = (rem_q >= dsh_q);

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  // The quotient is only needed up to the screen range, so a single compare
  // against den << SCREEN_BITS catches every larger result and saturates it.
  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    den_d   = den_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          mag_d   = req_i.mag;
          den_d   = req_i.den;
          state_d = DV_MUL;
        end
      end
      DV_MUL: begin
        rem_d   = prod;
        dsh_d   = PROD_BITS'({den_q, {(SCREEN_BITS-1){1'b0}}});
        state_d = DV_CHECK;
      end
      DV_CHECK: begin
        if (rem_q >= (dsh_q << 1)) begin
          quo_d   = '1;
          done_d  = 1'b1;
          state_d = DV_IDLE;
        end else begin
          quo_d   = '0;
          cnt_d   = ITER_BITS'(SCREEN_BITS - 1);
          state_d = DV_ITER;
        end
      end
      DV_ITER: begin
        if (ge) begin
          rem_d = rem_q - dsh_q;
        end
        quo_d = {quo_q[SCREEN_BITS-2:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - ITER_BITS'(1);
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = DV_IDLE;
        end
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    den_q <= den_d;
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end
endmodule
`default_nettype wire

[hw/rtl/pbb_back.sv]
`default_nettype none
module pbb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pbb_pkg::cfg_t        cfg_i,
  input  logic                 q_valid_i,
  input  pbb_pkg::vert_entry_t q_entry_i,
  output logic                 q_pop_o,
  output pbb_pkg::div_req_t    div_req_o,
  input  pbb_pkg::div_rsp_t    div_rsp_i,
  pbb_box_if.source            box_o
);
  import pbb_pkg::*;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] lo;
    logic [SCREEN_BITS-1:0] hi;
  } ext_t;

  // Fold one projected value into an axis range. A negative projection pulls
  // the minimum to zero and never raises the maximum.
  function automatic ext_t track(ext_t cur, logic neg, logic [SCREEN_BITS-1:0] q,
                                 logic [SCREEN_BITS-1:0] limit);
    ext_t                   res;
    logic [SCREEN_BITS-1:0] hi_m;
    if (neg) begin
      res.lo = '0;
      hi_m   = cur.hi;
    end else begin
      res.lo = (q < cur.lo) ? q : cur.lo;
      hi_m   = (q > cur.hi) ? q : cur.hi;
    end
    res.hi = (hi_m >= limit) ? limit : hi_m;
    return res;
  endfunction

  back_state_e            state_q, state_d;
  logic [SCREEN_BITS-1:0] min_x_q, min_x_d, max_x_q, max_x_d;
  logic [SCREEN_BITS-1:0] min_y_q, min_y_d, max_y_q, max_y_d;
  logic                   behind_q, behind_d;
  logic                   fresh_q, fresh_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  logic [SCREEN_BITS-1:0] box_x_q, box_y_q, box_w_q, box_h_q;
  logic                   box_behind_q;
  logic [SCREEN_BITS-1:0] box_x_d, box_y_d, box_w_d, box_h_d;
  ext_t                   ext_x, ext_y;

  assign ext_x = track('{lo: min_x_q, hi: max_x_q}, q_entry_i.x_neg, div_rsp_i.quo,
                       cfg_i.screen_w);
  assign ext_y = track('{lo: min_y_q, hi: max_y_q}, q_entry_i.y_neg, div_rsp_i.quo,
                       cfg_i.screen_h);

  always_comb begin
    box_x_d = behind_q ? '0 : min_x_q;
    box_y_d = behind_q ? '0 : min_y_q;
    box_w_d = (!behind_q && (max_x_q > min_x_q)) ? max_x_q - min_x_q : '0;
    box_h_d = (!behind_q && (max_y_q > min_y_q)) ? max_y_q - min_y_q : '0;
  end

  always_comb begin
    state_d         = state_q;
    min_x_d         = min_x_q;
    max_x_d         = max_x_q;
    min_y_d         = min_y_q;
    max_y_d         = max_y_q;
    behind_d        = behind_q;
    fresh_d         = fresh_q;
    out_valid_d     = out_valid_q && !box_o.ready;
    out_load        = 1'b0;
    q_pop_o         = 1'b0;
    div_req_o.start = 1'b0;
    div_req_o.mag   = q_entry_i.x_mag;
    div_req_o.den   = q_entry_i.z_mag;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          if (fresh_q) begin
            min_x_d  = cfg_i.screen_w;
            max_x_d  = '0;
            min_y_d  = cfg_i.screen_h;
            max_y_d  = '0;
            behind_d = 1'b0;
            fresh_d  = 1'b0;
          end
          if (q_entry_i.behind) begin
            behind_d = 1'b1;
            state_d  = BK_FINISH;
          end else begin
            div_req_o.start = 1'b1;
            state_d         = BK_DIV_X;
          end
        end
      end
      BK_DIV_X: begin
        if (div_rsp_i.done) begin
          min_x_d         = ext_x.lo;
          max_x_d         = ext_x.hi;
          div_req_o.start = 1'b1;
          div_req_o.mag   = q_entry_i.y_mag;
          state_d         = BK_DIV_Y;
        end
      end
      BK_DIV_Y: begin
        if (div_rsp_i.done) begin
          min_y_d = ext_y.lo;
          max_y_d = ext_y.hi;
          state_d = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (!q_entry_i.last) begin
          q_pop_o = 1'b1;
          state_d = BK_IDLE;
        end else if (!out_valid_q || box_o.ready) begin
          out_valid_d = 1'b1;
          out_load    = 1'b1;
          q_pop_o     = 1'b1;
          fresh_d     = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      min_x_q     <= SCREEN_W_RESET;
      max_x_q     <= '0;
      min_y_q     <= SCREEN_H_RESET;
      max_y_q     <= '0;
      behind_q    <= 1'b0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_x_q     <= min_x_d;
      max_x_q     <= max_x_d;
      min_y_q     <= min_y_d;
      max_y_q     <= max_y_d;
      behind_q    <= behind_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      box_x_q      <= box_x_d;
      box_y_q      <= box_y_d;
      box_w_q      <= box_w_d;
      box_h_q      <= box_h_d;
      box_behind_q <= behind_q;
    end
  end

  assign box_o.valid         = out_valid_q;
  assign box_o.box_x         = box_x_q;
  assign box_o.box_y         = box_y_q;
  assign box_o.box_w         = box_w_q;
  assign box_o.box_h         = box_h_q;
  assign box_o.behind_camera = box_behind_q;
endmodule
`default_nettype wire
